// ===== hdl/qrs_pkg.sv =====
`timescale 1ns / 1ps
package qrs_pkg;
  localparam int CoefWidth = 16;
  localparam int RootWidth = 32;
  localparam int DeltaWidth = 2 * CoefWidth + 3;
  localparam int SqIn = DeltaWidth + 16;
  localparam int SqOut = (SqIn + 1) / 2;
  localparam int NumWidth = SqOut + 9 + 2;
  localparam int DivWidth = NumWidth + 8;
  localparam int QuotWidth = DivWidth;
  localparam int MagA = CoefWidth;

  typedef struct packed {
    logic [RootWidth-1:0] root1_real;
    logic [RootWidth-1:0] root1_imag;
    logic [RootWidth-1:0] root2_real;
    logic [RootWidth-1:0] root2_imag;
    logic [1:0] real_root_count;
    logic degenerate;
    logic saturated;
  } res_t;

  typedef struct packed {
    logic degenerate;
    logic neg_delta;
    logic zero_delta;
    logic neg_a;
  } flags_t;
endpackage

// ===== hdl/qrs_sqrt.sv =====
`timescale 1ns / 1ps
module qrs_sqrt (
  input  logic clk,
  input  logic en,
  input  logic [qrs_pkg::SqIn-1:0] radicand,
  output logic [qrs_pkg::SqOut-1:0] root
);
  import qrs_pkg::*;

  logic [SqIn-1:0] rem_q [SqOut+1];
  logic [SqOut-1:0] rt_q [SqOut+1];

  always_comb begin
    rem_q[0] = radicand;
    rt_q[0] = '0;
  end

  for (genvar i = 0; i < SqOut; i++) begin : g_step
    localparam int Sh = 2 * (SqOut - 1 - i);
    logic [SqIn+1:0] trial;
    logic [SqIn+1:0] cur;
    logic fits;
    always_comb begin
      trial = ({{(SqIn + 2 - SqOut){1'b0}}, rt_q[i]} << (SqOut - i))
              | ({{(SqIn + 1){1'b0}}, 1'b1} << Sh);
      cur = {2'b00, rem_q[i]};
      fits = cur >= trial;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i+1] <= fits ? rem_q[i] - trial[SqIn-1:0] : rem_q[i];
        rt_q[i+1] <= fits ? rt_q[i] | (SqOut'(1) << (SqOut - 1 - i)) : rt_q[i];
      end
    end
  end

  assign root = rt_q[SqOut];
endmodule

// ===== hdl/qrs_div.sv =====
`timescale 1ns / 1ps
module qrs_div (
  input  logic clk,
  input  logic en,
  input  logic [qrs_pkg::DivWidth-1:0] dividend,
  input  logic [qrs_pkg::MagA-1:0] divisor,
  output logic [qrs_pkg::QuotWidth-1:0] quotient
);
  import qrs_pkg::*;

  logic [MagA:0] rem_q [DivWidth+1];
  logic [DivWidth-1:0] num_q [DivWidth+1];
  logic [MagA-1:0] dv_q [DivWidth+1];

  always_comb begin
    rem_q[0] = '0;
    num_q[0] = dividend;
    dv_q[0] = divisor;
  end

  for (genvar i = 0; i < DivWidth; i++) begin : g_step
    logic [MagA+1:0] sh;
    logic ge;
    always_comb begin
      sh = {rem_q[i], num_q[i][DivWidth-1]};
      ge = sh >= {2'b00, dv_q[i]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i+1] <= ge ? (MagA + 1)'(sh - {2'b00, dv_q[i]}) : sh[MagA:0];
        num_q[i+1] <= {num_q[i][DivWidth-2:0], ge};
        dv_q[i+1] <= dv_q[i];
      end
    end
  end

  assign quotient = num_q[DivWidth];
endmodule

// ===== hdl/quadratic_root_solver_top.sv =====
`timescale 1ns / 1ps
// Quadratic root solver: one coefficient set in, one root set out.
// Input stream s_axis: tdata carries coef_a, coef_b, coef_c (16 bits each, Q8.8).
// Output stream m_axis: tdata carries root1_real, root1_imag, root2_real,
// root2_imag (Q16.16), real_root_count, degenerate and saturated.
// One request is taken every cycle while the output side keeps up.
// The pipeline has 73 register stages: discriminant (1), the bit-serial
// square root pipeline (26, one root bit per stage), the restoring divider
// pipeline (45, one quotient bit per stage), then a rounding/saturating
// output register (1).
// The whole pipeline advances as one; when m_axis_tvalid is high and m_axis_tready
// is low every stage holds, and s_axis_tready follows m_axis_tready when the output
// is full, so nothing is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
// A zero coefficient a gives the degenerate flag with all roots zero.
module quadratic_root_solver_top (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // coef_a, coef_b, coef_c
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [135:0] m_axis_tdata  // root1_real, root1_imag, root2_real,
                                     // root2_imag, real_root_count, degenerate,
                                     // saturated, zero fill
);
  import qrs_pkg::*;

  localparam int Lat = SqOut + DivWidth + 2;

  logic en;
  logic [Lat-1:0] vld;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[Lat-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Lat-2:0], s_axis_tvalid};
  end

  // stage 0: discriminant
  logic signed [CoefWidth-1:0] a_in, b_in, c_in;
  assign a_in = s_axis_tdata[15:0];
  assign b_in = s_axis_tdata[31:16];
  assign c_in = s_axis_tdata[47:32];

  logic signed [2*CoefWidth-1:0] bb, ac;
  assign bb = b_in * b_in;
  assign ac = a_in * c_in;

  logic signed [DeltaWidth-1:0] delta;
  logic [DeltaWidth-1:0] dmag;
  logic signed [CoefWidth-1:0] a0, b0;
  flags_t f0;
  always_ff @(posedge clk) begin
    if (en) begin
      delta <= DeltaWidth'(bb) - (DeltaWidth'(ac) <<< 2);
      a0 <= a_in;
      b0 <= b_in;
    end
  end
  always_comb begin
    dmag = delta[DeltaWidth-1] ? -delta : delta;
    f0.degenerate = (a0 == '0);
    f0.neg_delta = delta[DeltaWidth-1];
    f0.zero_delta = (delta == '0);
    f0.neg_a = a0[CoefWidth-1];
  end

  logic [SqOut-1:0] s_root;
  qrs_sqrt u_sqrt (
    .clk(clk), .en(en),
    .radicand({dmag, 16'h0000}),
    .root(s_root)
  );

  logic signed [CoefWidth-1:0] a_d [SqOut+1];
  logic signed [CoefWidth-1:0] b_d [SqOut+1];
  flags_t f_d [SqOut+1];
  always_comb begin
    a_d[0] = a0; b_d[0] = b0; f_d[0] = f0;
  end
  for (genvar i = 0; i < SqOut; i++) begin : g_dl
    always_ff @(posedge clk) begin
      if (en) begin
        a_d[i+1] <= a_d[i]; b_d[i+1] <= b_d[i]; f_d[i+1] <= f_d[i];
      end
    end
  end

  // numerators, scaled by 2^8 for the Q16.16 quotient plus one round bit
  logic signed [NumWidth-1:0] nb, n1, n2, ni;
  logic [MagA-1:0] amag;
  always_comb begin
    nb = -(NumWidth'(b_d[SqOut]) <<< 8);
    n1 = nb - NumWidth'(s_root);
    n2 = nb + NumWidth'(s_root);
    ni = NumWidth'(s_root);
    amag = a_d[SqOut][CoefWidth-1] ? MagA'(-a_d[SqOut]) : MagA'(a_d[SqOut]);
  end

  function automatic logic [DivWidth-1:0] mag8(input logic signed [NumWidth-1:0] n);
    logic [NumWidth-1:0] m;
    m = n[NumWidth-1] ? -n : n;
    return {m, 8'h00};
  endfunction

  logic [QuotWidth-1:0] q1, q2, qi;
  logic [DivWidth-1:0] d1, d2, di;
  assign d1 = mag8(f_d[SqOut].neg_delta ? nb : n1);
  assign d2 = mag8(n2);
  assign di = mag8(ni);
  qrs_div u_div1 (.clk(clk), .en(en), .dividend(d1), .divisor(amag), .quotient(q1));
  qrs_div u_div2 (.clk(clk), .en(en), .dividend(d2), .divisor(amag), .quotient(q2));
  qrs_div u_divi (.clk(clk), .en(en), .dividend(di), .divisor(amag), .quotient(qi));

  // sign of the q1 and q2 quotients travels alongside
  logic [1:0] sg_d [DivWidth+1];
  flags_t fq_d [DivWidth+1];
  always_comb begin
    sg_d[0][0] = (f_d[SqOut].neg_delta ? nb[NumWidth-1] : n1[NumWidth-1])
                 ^ f_d[SqOut].neg_a;
    sg_d[0][1] = n2[NumWidth-1] ^ f_d[SqOut].neg_a;
    fq_d[0] = f_d[SqOut];
  end
  for (genvar i = 0; i < DivWidth; i++) begin : g_dq
    always_ff @(posedge clk) begin
      if (en) begin
        sg_d[i+1] <= sg_d[i]; fq_d[i+1] <= fq_d[i];
      end
    end
  end

  // quotient holds result*2 scale: round = (q+1)>>1 (ties away from zero)
  localparam int RW = QuotWidth + 1;
  function automatic logic signed [RW-1:0] rnd(input logic [QuotWidth-1:0] q,
                                               input logic neg);
    logic [RW-1:0] m;
    m = ({1'b0, q} + RW'(1)) >> 1;
    return neg ? -m : m;
  endfunction

  localparam logic signed [RW-1:0] Hi = RW'((64'sd1 <<< (RootWidth - 1)) - 1);
  localparam logic signed [RW-1:0] Lo = -Hi - RW'(1);

  logic signed [RW-1:0] v1, v2, vi, vlo, vhi;
  logic [RootWidth-1:0] s1, s2, si, sni;
  logic c1, c2, ci, cni;
  flags_t ff;
  always_comb begin
    ff = fq_d[DivWidth];
    v1 = rnd(q1, sg_d[DivWidth][0]);
    v2 = rnd(q2, sg_d[DivWidth][1]);
    vi = rnd(qi, 1'b0);
    if (ff.neg_delta) begin
      vlo = v1; vhi = v1;
    end else if (v1 > v2) begin
      vlo = v2; vhi = v1;
    end else begin
      vlo = v1; vhi = v2;
    end
    if (!ff.neg_delta) vi = '0;
    c1 = (vlo > Hi) || (vlo < Lo);
    s1 = (vlo > Hi) ? Hi[RootWidth-1:0] : (vlo < Lo) ? Lo[RootWidth-1:0] : vlo[RootWidth-1:0];
    c2 = (vhi > Hi) || (vhi < Lo);
    s2 = (vhi > Hi) ? Hi[RootWidth-1:0] : (vhi < Lo) ? Lo[RootWidth-1:0] : vhi[RootWidth-1:0];
    ci = vi > Hi;
    si = ci ? Hi[RootWidth-1:0] : vi[RootWidth-1:0];
    cni = -vi < Lo;
    sni = cni ? Lo[RootWidth-1:0] : RootWidth'(-vi);
  end

  res_t res;
  always_ff @(posedge clk) begin
    if (en) begin
      if (ff.degenerate) begin
        res <= '0;
        res.degenerate <= 1'b1;
      end else begin
        res.root1_real <= s1;
        res.root1_imag <= sni;
        res.root2_real <= s2;
        res.root2_imag <= si;
        res.real_root_count <= ff.neg_delta ? 2'd0 : ff.zero_delta ? 2'd1 : 2'd2;
        res.degenerate <= 1'b0;
        res.saturated <= c1 | c2 | ci | cni;
      end
    end
  end

  assign m_axis_tdata = {4'h0, res.saturated, res.degenerate, res.real_root_count,
                         res.root2_imag, res.root2_real, res.root1_imag, res.root1_real};
endmodule
